@@ design/oppu_pkg.sv @@
// Shared types, constants and helpers of the orthographic point projection unit.
`default_nettype none
package oppu_pkg;

   // Field widths
   localparam int LAT_W       = 16;
   localparam int LON_W       = 18;
   localparam int LON0_W      = 17;
   localparam int RADIUS_W    = 10;
   localparam int MARGIN_W    = 15;
   localparam int PROJ_W      = 19;
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_INDEX_W = 2;
   localparam int ANGLE_W     = 19;

   localparam int TRIG_FRAC_BITS_DEF = 15;

   // Angle units are 1/256 degree
   localparam int FULL_TURN = 92160;
   localparam int QUAD      = 23040;
   localparam int HALF_QUAD = 11520;

   // pi * 2^46 / 46080, radians per unit in Q46
   localparam logic [32:0] RAD_Q46 = 33'd4797524517;
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam int OUT_LIMIT = 261888;

   // Pipeline depths
   localparam int TRIG_LAT = 19;
   localparam int MIX_LAT  = 8;
   localparam int LATENCY  = 1 + TRIG_LAT + MIX_LAT;

   // Taylor series divisors, innermost Horner step first
   localparam int N_HORNER = 5;
   localparam int SIN_DIV [N_HORNER] = '{110, 72, 42, 20, 6};
   localparam int COS_DIV [N_HORNER] = '{132, 90, 56, 30, 12};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTER_LAT = 2'd0,
      CSR_CENTER_LON = 2'd1,
      CSR_RADIUS     = 2'd2,
      CSR_MARGIN     = 2'd3
   } csr_index_type;

   // Word carried through the Horner chains
   typedef struct packed {
      logic [29:0] x;
      logic [29:0] x2;
      logic [30:0] t;
      logic [1:0]  quad;
      logic        swap;
   } trig_bus_type;

   // Shift right by sh with halves rounded away from zero, sh >= 1
   function automatic longint round_away(input longint v, input int sh);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (longint'(1) <<< (sh - 1))) >>> sh;
      return (v < 0) ? -m : m;
   endfunction

endpackage
`default_nettype wire

@@ design/oppu_channels.sv @@
// Handshake channel interfaces: point request, projection response, register write.
`default_nettype none
interface oppu_req_if;
   import oppu_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [LAT_W-1:0] point_latitude;
   logic signed [LON_W-1:0] point_longitude;
   modport source(output valid, point_latitude, point_longitude, input ready);
   modport sink(input valid, point_latitude, point_longitude, output ready);
endinterface

interface oppu_rsp_if;
   import oppu_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [PROJ_W-1:0] proj_x;
   logic signed [PROJ_W-1:0] proj_y;
   logic                     point_visible;
   modport source(output valid, proj_x, proj_y, point_visible, input ready);
   modport sink(input valid, proj_x, proj_y, point_visible, output ready);
endinterface

interface oppu_csr_if;
   import oppu_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/oppu_horner.sv @@
// One Horner step of the Taylor series: t = 1 - (x2 * t) / DIVISOR, two stages.
`default_nettype none
module oppu_horner #(
   parameter int DIVISOR = 6
) (
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire oppu_pkg::trig_bus_type bus_i,
   output oppu_pkg::trig_bus_type      bus_o
);
   import oppu_pkg::*;

   // Exact reciprocal for dividends below 2^30
   localparam int SHIFT = 30 + $clog2(DIVISOR);
   localparam int QW    = SHIFT + 30;
   localparam logic [30:0] RECIP =
      31'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

   logic [60:0]   prod;
   logic [29:0]   p_in, p_ff;
   trig_bus_type  mid_ff;
   logic [QW-1:0] quot;
   trig_bus_type  bus_in, bus_ff;

   always_comb begin
      prod = 61'(bus_i.x2) * 61'(bus_i.t);
      p_in = prod[59:30];
      quot = QW'(p_ff) * QW'(RECIP);
      bus_in = mid_ff;
      bus_in.t = Q30_ONE - {1'b0, quot[SHIFT +: 30]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff   <= p_in;
         mid_ff <= bus_i;
         bus_ff <= bus_in;
      end
   end

   assign bus_o = bus_ff;
endmodule
`default_nettype wire

@@ design/oppu_trig.sv @@
// Pipelined sine and cosine of an angle in 1/256 degree, results in Q(F).
`default_nettype none
module oppu_trig #(
   parameter int TRIG_FRAC_BITS = oppu_pkg::TRIG_FRAC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  en,
   input  wire logic signed [oppu_pkg::ANGLE_W-1:0]   angle_i,
   output logic signed [TRIG_FRAC_BITS+1:0]           sin_o,
   output logic signed [TRIG_FRAC_BITS+1:0]           cos_o
);
   import oppu_pkg::*;

   localparam int F  = TRIG_FRAC_BITS;
   localparam int SH = 30 - F;
   localparam logic [31:0] HALF_RND = 32'd1 << (SH - 1);

   logic signed [20:0] cand;
   logic [16:0] u_in, u_ff;
   logic [1:0]  quad_in, quad_b_ff, quad_c_ff, quad_d_ff;
   logic [14:0] b_in, b_ff;
   logic        swap_in, swap_c_ff, swap_d_ff;
   logic [13:0] bb_in, bb_ff;
   logic [47:0] xr;
   logic [29:0] x_ff;
   logic [59:0] sq;
   trig_bus_type e_bus_in, e_bus_ff;
   trig_bus_type sin_bus [N_HORNER+1];
   trig_bus_type cos_bus [N_HORNER+1];

   logic [60:0] sin_prod, cos_prod;
   logic [29:0] sin_m_ff, sin_m2_ff, cos_p_ff;
   logic [30:0] cos_m_ff;
   logic [1:0]  quad_f_ff, quad_g_ff, quad_h_ff;
   logic        swap_f_ff, swap_g_ff;
   logic [31:0] rs_sum, rc_sum;
   logic [F:0]  ms_in, mc_in, ms_ff, mc_ff;
   logic signed [F+1:0] sp, cp, sin_in, cos_in, sin_ff, cos_ff;

   // Reduce modulo a full turn: exactly one candidate lands in range
   always_comb begin
      u_in = '0;
      cand = '0;
      for (int k = -2; k <= 3; k++) begin
         cand = 21'(angle_i) + 21'(k * FULL_TURN);
         if (cand >= 0 && cand < FULL_TURN) begin
            u_in = cand[16:0];
         end
      end
   end

   // Split into quadrant and offset
   always_comb begin
      if (u_ff >= 17'(3 * QUAD)) begin
         quad_in = 2'd3;
         b_in    = 15'(u_ff - 17'(3 * QUAD));
      end else if (u_ff >= 17'(2 * QUAD)) begin
         quad_in = 2'd2;
         b_in    = 15'(u_ff - 17'(2 * QUAD));
      end else if (u_ff >= 17'(QUAD)) begin
         quad_in = 2'd1;
         b_in    = 15'(u_ff - 17'(QUAD));
      end else begin
         quad_in = 2'd0;
         b_in    = u_ff[14:0];
      end
   end

   // Fold into the first octant
   assign swap_in = b_ff > 15'(HALF_QUAD);
   assign bb_in   = swap_in ? 14'(15'(QUAD) - b_ff) : b_ff[13:0];

   // Radians in Q30, then its square
   always_comb begin
      xr = 48'(bb_ff) * 48'(RAD_Q46) + 48'd32768;
      sq = 60'(x_ff) * 60'(x_ff);
      e_bus_in.x    = x_ff;
      e_bus_in.x2   = sq[59:30];
      e_bus_in.t    = Q30_ONE;
      e_bus_in.quad = quad_d_ff;
      e_bus_in.swap = swap_d_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff      <= u_in;
         quad_b_ff <= quad_in;
         b_ff      <= b_in;
         quad_c_ff <= quad_b_ff;
         swap_c_ff <= swap_in;
         bb_ff     <= bb_in;
         quad_d_ff <= quad_c_ff;
         swap_d_ff <= swap_c_ff;
         x_ff      <= xr[45:16];
         e_bus_ff  <= e_bus_in;
      end
   end

   assign sin_bus[0] = e_bus_ff;
   assign cos_bus[0] = e_bus_ff;

   for (genvar i = 0; i < N_HORNER; i++) begin : g_horner
      oppu_horner #(.DIVISOR(SIN_DIV[i])) u_sin_step (
         .clock(clock), .en(en), .bus_i(sin_bus[i]), .bus_o(sin_bus[i+1])
      );
      oppu_horner #(.DIVISOR(COS_DIV[i])) u_cos_step (
         .clock(clock), .en(en), .bus_i(cos_bus[i]), .bus_o(cos_bus[i+1])
      );
   end

   // Close the series, round to Q(F), then undo the fold and apply quadrant signs
   always_comb begin
      sin_prod = 61'(sin_bus[N_HORNER].x)  * 61'(sin_bus[N_HORNER].t);
      cos_prod = 61'(cos_bus[N_HORNER].x2) * 61'(cos_bus[N_HORNER].t);
      rs_sum   = 32'(sin_m2_ff) + HALF_RND;
      rc_sum   = 32'(cos_m_ff) + HALF_RND;
      ms_in    = swap_g_ff ? rc_sum[SH +: F+1] : rs_sum[SH +: F+1];
      mc_in    = swap_g_ff ? rs_sum[SH +: F+1] : rc_sum[SH +: F+1];
      sp       = $signed({1'b0, ms_ff});
      cp       = $signed({1'b0, mc_ff});
      case (quad_h_ff)
         2'd0: begin
            sin_in = sp;
            cos_in = cp;
         end
         2'd1: begin
            sin_in = cp;
            cos_in = -sp;
         end
         2'd2: begin
            sin_in = -sp;
            cos_in = -cp;
         end
         default: begin
            sin_in = -cp;
            cos_in = sp;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_m_ff  <= sin_prod[59:30];
         cos_p_ff  <= cos_prod[59:30];
         quad_f_ff <= cos_bus[N_HORNER].quad;
         swap_f_ff <= cos_bus[N_HORNER].swap;
         sin_m2_ff <= sin_m_ff;
         cos_m_ff  <= Q30_ONE - {2'b00, cos_p_ff[29:1]};
         quad_g_ff <= quad_f_ff;
         swap_g_ff <= swap_f_ff;
         ms_ff     <= ms_in;
         mc_ff     <= mc_in;
         quad_h_ff <= quad_g_ff;
         sin_ff    <= sin_in;
         cos_ff    <= cos_in;
      end
   end

   assign sin_o = sin_ff;
   assign cos_o = cos_ff;
endmodule
`default_nettype wire

@@ design/oppu_mix.sv @@
// Products of the trig terms, radius scaling, saturation and visibility test.
`default_nettype none
module oppu_mix #(
   parameter int TRIG_FRAC_BITS = oppu_pkg::TRIG_FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 en,
   input  wire logic signed [TRIG_FRAC_BITS+1:0]     sl_i,
   input  wire logic signed [TRIG_FRAC_BITS+1:0]     cl_i,
   input  wire logic signed [TRIG_FRAC_BITS+1:0]     s0_i,
   input  wire logic signed [TRIG_FRAC_BITS+1:0]     c0_i,
   input  wire logic signed [TRIG_FRAC_BITS+1:0]     sd_i,
   input  wire logic signed [TRIG_FRAC_BITS+1:0]     cd_i,
   input  wire logic [oppu_pkg::RADIUS_W-1:0]        radius_i,
   input  wire logic [oppu_pkg::MARGIN_W-1:0]        margin_i,
   output logic signed [oppu_pkg::PROJ_W-1:0]        proj_x_o,
   output logic signed [oppu_pkg::PROJ_W-1:0]        proj_y_o,
   output logic                                      visible_o
);
   import oppu_pkg::*;

   localparam int F  = TRIG_FRAC_BITS;
   localparam int PW = 2 * F + 4;
   localparam int SW = F + 3;
   localparam int RW = F + 14;

   typedef logic signed [F+1:0] trig_type;
   typedef logic signed [PW-1:0] prod_type;

   prod_type pr_clcd_ff, pr_s0sl_ff, pr_c0sl_ff, pr_xi_ff, pr_c0cc_ff, pr_s0cc_ff;
   trig_type s0_a_ff, c0_a_ff, s0_b_ff, c0_b_ff;
   trig_type clcd_ff, a_ff, b_ff, xi_ff, a_c_ff, b_c_ff, xi_c_ff;
   trig_type e_ff, f_ff, a_d_ff, b_d_ff, xi_d_ff;
   logic signed [SW-1:0] dist_ff, yi_ff, xi_e_ff;
   logic signed [RW-1:0] rx_ff, ry_ff;
   logic                 vis_f_ff, vis_g_ff, vis_ff;
   longint               rx_in, ry_in, marg;
   logic signed [PROJ_W-1:0] px_g_ff, py_g_ff, px_ff, py_ff;

   // Margin brought from Q15 to Q(F)
   always_comb begin
      if (F >= 15) begin
         marg = longint'(margin_i) <<< (F - 15);
      end else begin
         marg = longint'(margin_i) >>> (15 - F);
      end
   end

   always_comb begin
      rx_in = round_away(longint'(rx_ff), F - 8);
      ry_in = round_away(longint'(ry_ff), F - 8);
   end

   function automatic logic signed [PROJ_W-1:0] clamp(input longint v);
      longint c;
      c = v;
      if (c > longint'(OUT_LIMIT)) begin
         c = longint'(OUT_LIMIT);
      end
      if (c < -longint'(OUT_LIMIT)) begin
         c = -longint'(OUT_LIMIT);
      end
      return PROJ_W'(c);
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         // first products
         pr_clcd_ff <= PW'(cl_i) * PW'(cd_i);
         pr_s0sl_ff <= PW'(s0_i) * PW'(sl_i);
         pr_c0sl_ff <= PW'(c0_i) * PW'(sl_i);
         pr_xi_ff   <= PW'(cl_i) * PW'(sd_i);
         s0_a_ff    <= s0_i;
         c0_a_ff    <= c0_i;
         // round to Q(F)
         clcd_ff    <= (F+2)'(round_away(longint'(pr_clcd_ff), F));
         a_ff       <= (F+2)'(round_away(longint'(pr_s0sl_ff), F));
         b_ff       <= (F+2)'(round_away(longint'(pr_c0sl_ff), F));
         xi_ff      <= (F+2)'(round_away(longint'(pr_xi_ff), F));
         s0_b_ff    <= s0_a_ff;
         c0_b_ff    <= c0_a_ff;
         // centre terms against cos(lat)*cos(dlon)
         pr_c0cc_ff <= PW'(c0_b_ff) * PW'(clcd_ff);
         pr_s0cc_ff <= PW'(s0_b_ff) * PW'(clcd_ff);
         a_c_ff     <= a_ff;
         b_c_ff     <= b_ff;
         xi_c_ff    <= xi_ff;
         e_ff       <= (F+2)'(round_away(longint'(pr_c0cc_ff), F));
         f_ff       <= (F+2)'(round_away(longint'(pr_s0cc_ff), F));
         a_d_ff     <= a_c_ff;
         b_d_ff     <= b_c_ff;
         xi_d_ff    <= xi_c_ff;
         // distance cosine and inner y
         dist_ff    <= SW'(a_d_ff) + SW'(e_ff);
         yi_ff      <= SW'(b_d_ff) - SW'(f_ff);
         xi_e_ff    <= SW'(xi_d_ff);
         // scale by radius, test visibility
         rx_ff      <= RW'($signed({1'b0, radius_i})) * RW'(xi_e_ff);
         ry_ff      <= RW'($signed({1'b0, radius_i})) * RW'(yi_ff);
         vis_f_ff   <= longint'(dist_ff) > -marg;
         px_g_ff    <= clamp(rx_in);
         py_g_ff    <= clamp(ry_in);
         vis_g_ff   <= vis_f_ff;
         px_ff      <= px_g_ff;
         py_ff      <= py_g_ff;
         vis_ff     <= vis_g_ff;
      end
   end

   assign proj_x_o  = px_ff;
   assign proj_y_o  = py_ff;
   assign visible_o = vis_ff;
endmodule
`default_nettype wire

@@ design/orthographic_point_projection_unit.sv @@
// Top level of the orthographic point projection unit.
// Throughput: one point per cycle; the whole pipeline advances together and
//   freezes only while the response word waits unread (rsp ready low).
// Depth: 1 angle stage, 19 sine/cosine stages (ten of them inside the Horner steps), 8 mix stages.
// Reset (synchronous) clears the valid pipe and loads the register defaults.
`default_nettype none
module orthographic_point_projection_unit #(
   parameter int TRIG_FRAC_BITS = oppu_pkg::TRIG_FRAC_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   oppu_req_if.sink  req_if,
   oppu_rsp_if.source rsp_if,
   oppu_csr_if.sink  csr_if
);
   import oppu_pkg::*;

   localparam int F = TRIG_FRAC_BITS;

   // Configuration registers
   logic signed [LAT_W-1:0]  center_lat_ff;
   logic signed [LON0_W-1:0] center_lon_ff;
   logic [RADIUS_W-1:0]      radius_ff;
   logic [MARGIN_W-1:0]      margin_ff;

   // Pipeline control
   logic               en;
   logic [LATENCY-1:0] vld_ff;

   // Angle stage
   logic signed [ANGLE_W-1:0] lat_ang_ff, lat0_ang_ff, dlon_ang_ff;
   logic signed [F+1:0] sl, cl, s0, c0, sd, cd;

   // Advance whenever the output word is empty or being taken
   assign en            = !vld_ff[LATENCY-1] || rsp_if.ready;
   assign req_if.ready  = en;
   assign csr_if.ready  = 1'b1;
   assign rsp_if.valid  = vld_ff[LATENCY-1];

   // Register writes; unknown indexes cannot occur with a two-bit index
   always_ff @(posedge clock) begin
      if (reset) begin
         center_lat_ff <= LAT_W'(5120);
         center_lon_ff <= '0;
         radius_ff     <= RADIUS_W'(10);
         margin_ff     <= MARGIN_W'(3);
      end else if (csr_if.valid) begin
         case (csr_index_type'(csr_if.index))
            CSR_CENTER_LAT: center_lat_ff <= csr_if.data[LAT_W-1:0];
            CSR_CENTER_LON: center_lon_ff <= csr_if.data[LON0_W-1:0];
            CSR_RADIUS:     radius_ff     <= csr_if.data[RADIUS_W-1:0];
            CSR_MARGIN:     margin_ff     <= csr_if.data[MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Valid bits ride alongside the data, shifting only when enabled
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LATENCY-2:0], req_if.valid};
      end
   end

   // Capture the three angles; longitude difference is taken here
   always_ff @(posedge clock) begin
      if (en) begin
         lat_ang_ff  <= ANGLE_W'(req_if.point_latitude);
         lat0_ang_ff <= ANGLE_W'(center_lat_ff);
         dlon_ang_ff <= ANGLE_W'(req_if.point_longitude) - ANGLE_W'(center_lon_ff);
      end
   end

   // Three trig units in lockstep: point latitude, centre latitude, longitude offset
   oppu_trig #(.TRIG_FRAC_BITS(F)) u_trig_lat (
      .clock(clock), .en(en), .angle_i(lat_ang_ff), .sin_o(sl), .cos_o(cl)
   );
   oppu_trig #(.TRIG_FRAC_BITS(F)) u_trig_lat0 (
      .clock(clock), .en(en), .angle_i(lat0_ang_ff), .sin_o(s0), .cos_o(c0)
   );
   oppu_trig #(.TRIG_FRAC_BITS(F)) u_trig_dlon (
      .clock(clock), .en(en), .angle_i(dlon_ang_ff), .sin_o(sd), .cos_o(cd)
   );

   // Combine, scale and test; its last stage is the output register
   oppu_mix #(.TRIG_FRAC_BITS(F)) u_mix (
      .clock(clock), .en(en),
      .sl_i(sl), .cl_i(cl), .s0_i(s0), .c0_i(c0), .sd_i(sd), .cd_i(cd),
      .radius_i(radius_ff), .margin_i(margin_ff),
      .proj_x_o(rsp_if.proj_x), .proj_y_o(rsp_if.proj_y),
      .visible_o(rsp_if.point_visible)
   );

   // A stalled pipeline must hold every valid bit in place
   assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("valid pipe moved during stall");

   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.proj_x <= PROJ_W'(OUT_LIMIT)) &&
                       (rsp_if.proj_x >= -PROJ_W'(OUT_LIMIT)))
      else $error("proj_x outside saturation limit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.proj_y <= PROJ_W'(OUT_LIMIT)) &&
                       (rsp_if.proj_y >= -PROJ_W'(OUT_LIMIT)))
      else $error("proj_y outside saturation limit");

   assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("response valid after reset");
endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench of the orthographic point projection unit.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import oppu_pkg::*;

   localparam int TRIG_F      = TRIG_FRAC_BITS_DEF;
   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_ITEMS = 1200;

   typedef struct {
      logic signed [PROJ_W-1:0] proj_x;
      logic signed [PROJ_W-1:0] proj_y;
      logic                     point_visible;
   } projection_type;

   logic clock;
   logic reset;
   int   cycle_count;
   int   mismatch_count;

   // Local copy of the register file, updated when a register word is accepted
   logic [LAT_W-1:0]    lat0_reg;
   logic [LON0_W-1:0]   lon0_reg;
   logic [RADIUS_W-1:0] radius_reg;
   logic [MARGIN_W-1:0] margin_reg;

   projection_type expected_projections[$];

   // Idling knobs of the sender and of the receiver
   bit sender_gaps_on;
   bit receiver_stalls_on;
   int receiver_hold_request;

   oppu_req_if req_bus ();
   oppu_rsp_if rsp_bus ();
   oppu_csr_if csr_bus ();

   orthographic_point_projection_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Projection predictor
   // ---------------------------------------------------------------------

   // Shift right with halves rounded away from zero
   function automatic longint shift_round_away(input longint v, input int sh);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (longint'(1) <<< (sh - 1))) >>> sh;
      return (v < 0) ? -m : m;
   endfunction

   // Sine and cosine magnitudes in Q30 for b in [0, 45 deg]
   function automatic void octant_sincos(input longint unsigned b,
                                         output longint unsigned s,
                                         output longint unsigned c);
      longint unsigned one, x, x2, t;
      int sin_div [5];
      int cos_div [5];
      sin_div = '{110, 72, 42, 20, 6};
      cos_div = '{132, 90, 56, 30, 12};
      one = 64'd1 << 30;
      x   = (b * 64'(RAD_Q46) + (64'd1 << 15)) >> 16;
      x2  = (x * x) >> 30;
      t   = one;
      for (int k = 0; k < 5; k++)
         t = one - ((x2 * t) >> 30) / longint'(sin_div[k]);
      s = (x * t) >> 30;
      t = one;
      for (int k = 0; k < 5; k++)
         t = one - ((x2 * t) >> 30) / longint'(cos_div[k]);
      c = one - ((x2 * t) >> 30) / 64'd2;
   endfunction

   function automatic longint q30_to_qf(input longint unsigned v);
      return longint'((v + (64'd1 << (29 - TRIG_F))) >> (30 - TRIG_F));
   endfunction

   // Signed sine and cosine in Q(F) of an angle in 1/256 degree, any range
   function automatic void angle_sincos(input longint a, output longint sn,
                                        output longint cs);
      longint r, s, c;
      longint unsigned b, ms, mc;
      int quadrant;
      r = a % FULL_TURN;
      if (r < 0) r += FULL_TURN;
      quadrant = int'(r / QUAD);
      b = longint'(r % QUAD);
      if (b <= HALF_QUAD) octant_sincos(b, ms, mc);
      else octant_sincos(QUAD - b, mc, ms);
      s = q30_to_qf(ms);
      c = q30_to_qf(mc);
      case (quadrant)
         0: begin sn = s;  cs = c;  end
         1: begin sn = c;  cs = -s; end
         2: begin sn = -s; cs = -c; end
         default: begin sn = -c; cs = s; end
      endcase
   endfunction

   function automatic longint qf_mul(input longint a, input longint b);
      return shift_round_away(a * b, TRIG_F);
   endfunction

   function automatic longint scale_saturate(input longint inner);
      longint v;
      v = shift_round_away(longint'(radius_reg) * inner, TRIG_F - 8);
      if (v > OUT_LIMIT) v = OUT_LIMIT;
      if (v < -OUT_LIMIT) v = -OUT_LIMIT;
      return v;
   endfunction

   function automatic projection_type project_point(input logic signed [LAT_W-1:0] lat,
                                                    input logic signed [LON_W-1:0] lon);
      projection_type p;
      longint sl, cl, s0, c0, sd, cd, clcd, dist_cos, xi, yi, marg;
      angle_sincos(longint'(lat), sl, cl);
      angle_sincos(longint'($signed(lat0_reg)), s0, c0);
      angle_sincos(longint'(lon) - longint'($signed(lon0_reg)), sd, cd);
      clcd     = qf_mul(cl, cd);
      dist_cos = qf_mul(s0, sl) + qf_mul(c0, clcd);
      yi       = qf_mul(c0, sl) - qf_mul(s0, clcd);
      xi       = qf_mul(cl, sd);
      if (TRIG_F >= 15) marg = longint'(margin_reg) <<< (TRIG_F - 15);
      else marg = longint'(margin_reg) >>> (15 - TRIG_F);
      p.proj_x        = PROJ_W'(scale_saturate(xi));
      p.proj_y        = PROJ_W'(scale_saturate(yi));
      p.point_visible = (dist_cos > -marg);
      return p;
   endfunction

   // ---------------------------------------------------------------------
   // Response side: check each word, then draw the next stall
   // ---------------------------------------------------------------------
   int stall_left;
   int hold_left;

   always @(posedge clock) begin
      projection_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_projections.size() == 0) begin
            $error("response word with no point outstanding");
            mismatch_count++;
         end else begin
            want = expected_projections.pop_front();
            if (rsp_bus.proj_x !== want.proj_x) begin
               $error("proj_x expected %0d actual %0d", want.proj_x, rsp_bus.proj_x);
               mismatch_count++;
            end
            if (rsp_bus.proj_y !== want.proj_y) begin
               $error("proj_y expected %0d actual %0d", want.proj_y, rsp_bus.proj_y);
               mismatch_count++;
            end
            if (rsp_bus.point_visible !== want.point_visible) begin
               $error("point_visible expected %0d actual %0d",
                      want.point_visible, rsp_bus.point_visible);
               mismatch_count++;
            end
         end
         stall_left = receiver_stalls_on ? $urandom_range(0, 8) : 0;
      end
      // A long hold-off request overrides the per-word stall
      if (receiver_hold_request > 0) begin
         hold_left = receiver_hold_request;
         receiver_hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offer one point word; predict it once accepted. Valid stays high on exit.
   task automatic send_point(input logic signed [LAT_W-1:0] lat,
                             input logic signed [LON_W-1:0] lon);
      int gap;
      gap = sender_gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.point_latitude  <= lat;
      req_bus.point_longitude <= lon;
      do @(posedge clock); while (!req_bus.ready);
      expected_projections.push_back(project_point(lat, lon));
   endtask

   task automatic end_points();
      req_bus.valid <= 1'b0;
   endtask

   // Hold until every response is back, then let the pipe settle
   task automatic wait_drained();
      while (expected_projections.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   // Write one register; only called with the block idle
   task automatic write_register(input csr_index_type idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_CENTER_LAT: lat0_reg   = value[LAT_W-1:0];
         CSR_CENTER_LON: lon0_reg   = value[LON0_W-1:0];
         CSR_RADIUS:     radius_reg = value[RADIUS_W-1:0];
         CSR_MARGIN:     margin_reg = value[MARGIN_W-1:0];
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int lat0, input int lon0, input int radius,
                            input int margin);
      end_points();
      wait_drained();
      write_register(CSR_CENTER_LAT, CSR_DATA_W'(lat0));
      write_register(CSR_CENTER_LON, CSR_DATA_W'(lon0));
      write_register(CSR_RADIUS, CSR_DATA_W'(radius));
      write_register(CSR_MARGIN, CSR_DATA_W'(margin));
   endtask

   // Mostly legal coordinates; now and then raw bits to reach the wrap logic
   task automatic send_random_point();
      logic signed [LAT_W-1:0] lat;
      logic signed [LON_W-1:0] lon;
      if ($urandom_range(0, 7) == 0) begin
         lat = LAT_W'($urandom);
         lon = LON_W'($urandom);
      end else begin
         lat = LAT_W'(int'($urandom_range(0, 46080)) - 23040);
         lon = LON_W'(int'($urandom_range(0, 184320)) - 92160);
      end
      send_point(lat, lon);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Field extremes, quadrant and octant edges, wrap past one turn
   task automatic test_directed_points();
      int lats [8];
      int lons [8];
      lats = '{0, 23040, -23040, 11520, -11519, 32767, -32768, 11521};
      lons = '{0, 92160, -92160, 23040, 46080, 69120, 131071, -131072};
      for (int k = 0; k < 8; k++) send_point(LAT_W'(lats[k]), LON_W'(lons[k]));
      send_point(LAT_W'(0), LON_W'(11520));
      send_point(LAT_W'(5120), LON_W'(46080));
      send_point(LAT_W'(-5120), LON_W'(-46080));
   endtask

   // Zero radius, saturating radius and unit radius, each on its own points
   task automatic test_radius_extremes();
      configure(0, 0, 0, 0);
      send_point(LAT_W'(1000), LON_W'(2000));
      send_point(LAT_W'(-23040), LON_W'(46080));
      configure(0, 0, 1023, 32767);
      send_point(LAT_W'(0), LON_W'(0));
      send_point(LAT_W'(0), LON_W'(23040));
      send_point(LAT_W'(23040), LON_W'(0));
      send_point(LAT_W'(-23040), LON_W'(-23040));
      send_point(LAT_W'(0), LON_W'(46080));
      configure(23040, -46080, 1, 0);
      send_point(LAT_W'(0), LON_W'(0));
      send_point(LAT_W'(-23040), LON_W'(-46080));
   endtask

   // Sweep centers and scales, each with a batch of random points
   task automatic test_center_sweep();
      configure(-23040, 46080, 1023, 3);
      repeat (100) send_random_point();
      configure(5120, 0, 10, 3);
      repeat (100) send_random_point();
      for (int k = 0; k < 4; k++) begin
         configure(int'($urandom), int'($urandom), int'($urandom), int'($urandom));
         repeat (75) send_random_point();
      end
   endtask

   // Fill the pipe against a stalled receiver, drain with the sender held, then resume with gaps
   task automatic test_backpressure();
      sender_gaps_on = 1'b0;
      receiver_hold_request = 120;
      repeat (80) send_random_point();
      sender_gaps_on = 1'b1;
      end_points();
      while (expected_projections.size() != 0) @(posedge clock);
      repeat (100) send_random_point();
   endtask

   // Long random stream with idling switched per stretch
   task automatic test_random_stream();
      configure(int'($urandom_range(0, 46080)) - 23040,
                int'($urandom_range(0, 92160)) - 46080,
                $urandom_range(1, 1023), $urandom_range(0, 32767));
      for (int k = 0; k < RANDOM_ITEMS - 700; k++) begin
         if (k % 100 == 0) begin
            sender_gaps_on     = ($urandom_range(0, 3) != 0);
            receiver_stalls_on = ($urandom_range(0, 3) != 0);
         end
         send_random_point();
      end
      end_points();
   endtask

   initial begin
      reset                   <= 1'b1;
      req_bus.valid           <= 1'b0;
      req_bus.point_latitude  <= '0;
      req_bus.point_longitude <= '0;
      csr_bus.valid           <= 1'b0;
      csr_bus.index           <= CSR_CENTER_LAT;
      csr_bus.data            <= '0;
      cycle_count    = 0;
      mismatch_count = 0;
      stall_left     = 0;
      hold_left      = 0;
      receiver_hold_request = 0;
      sender_gaps_on     = 1'b1;
      receiver_stalls_on = 1'b1;
      // Register defaults after reset
      lat0_reg   = LAT_W'(5120);
      lon0_reg   = '0;
      radius_reg = RADIUS_W'(10);
      margin_reg = MARGIN_W'(3);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_points();
      test_radius_extremes();
      test_center_sweep();
      test_backpressure();
      test_random_stream();

      // Drop valid, drain, then give the pipe time to show stray words
      end_points();
      while (expected_projections.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
`default_nettype wire
